// File: hdl/htik_pkg.sv
// ----------------------------------------------------------------------------
// htik_pkg: shared types and constants of the integer-key hash table
// Sizes, action and status codes, and the controller/datapath command and
// status bundles.
// ----------------------------------------------------------------------------
package htik_pkg;

    localparam int NUM_BUCKETS      = 256;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int TOTAL_SLOTS      = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int SLOT_W           = $clog2(TOTAL_SLOTS);
    localparam int SUB_W            = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int BKT_W            = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W            = 12;
    localparam int CFG_W            = 9;
    localparam int HASH_W           = 32;
    localparam logic [31:0] MIX_MUL = 32'h045d9f3b;
    localparam int MIX_SHIFT        = 16;

    localparam logic [1:0] ACT_PUT    = 2'd0;
    localparam logic [1:0] ACT_GET    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FND  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic mix_a;     // first xor-shift/multiply
        logic mix_b;     // second xor-shift/multiply
        logic mix_c;     // final xor-shift, start modulo
        logic mod_step;  // one restoring-division step
        logic scan_rd;   // issue slot read
        logic scan_chk;  // check the read slot
        logic commit;    // apply write and form result
    } htik_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic scan_last;
        logic act_valid;
        logic clr_done;  // valid store cleared after reset
    } htik_sts_t;

endpackage

// File: hdl/hash_table_int_keys.sv
// ----------------------------------------------------------------------------
// hash_table_int_keys: key-value table with 32-bit integer keys
// Each item passes three hash steps, the modulo, one slot read, the slot
// checks and a commit; the unused action skips the modulo and the scan.
// One item at a time: a new item is taken only in idle, and only as the
// held result leaves or once it has left.
// Reset (aresetn low, synchronous) clears count, bucket_count=256; then a
// pass over all 2048 slots clears the valid bits while the input is held off.
// ----------------------------------------------------------------------------
module hash_table_int_keys (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // action[1:0], key[33:2], value_in[65:34], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // found[0], value_out[32:1], status[34:33], entry_count[46:35]
);

    htik_pkg::htik_cmd_t cmd;
    htik_pkg::htik_sts_t sts;
    logic [htik_pkg::CFG_W-1:0] bcount_reg;
    logic        found;
    logic [31:0] vout;
    logic [1:0]  status;
    logic [htik_pkg::CNT_W-1:0] cnt;

    // hold the bucket count register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            bcount_reg <= htik_pkg::CFG_W'(256);
        else if (cfg_we)
            bcount_reg <= cfg_wdata;
    end

    htik_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .sts(sts)
    );

    htik_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_action(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_value(s_tdata[65:34]),
        .bucket_count(bcount_reg),
        .res_found(found), .res_value(vout), .res_status(status), .res_count(cnt)
    );

    assign m_tdata = {1'b0, cnt, status, vout, found};

endmodule

// File: hdl/htik_datapath.sv
// ----------------------------------------------------------------------------
// htik_datapath: hash, modulo, slot scan and table storage
// Mixes the key over three steps, reduces it by a bit-serial restoring
// divider, then reads the bucket's slots one a cycle from the stores.
// ----------------------------------------------------------------------------
module htik_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  htik_pkg::htik_cmd_t      cmd,
    output htik_pkg::htik_sts_t      sts,
    input  logic [1:0]               in_action,
    input  logic [31:0]              in_key,
    input  logic [31:0]              in_value,
    input  logic [htik_pkg::CFG_W-1:0] bucket_count,
    output logic                     res_found,
    output logic [31:0]              res_value,
    output logic [1:0]               res_status,
    output logic [htik_pkg::CNT_W-1:0] res_count
);

    localparam int SW = htik_pkg::SLOT_W;
    localparam int UW = htik_pkg::SUB_W;

    logic [1:0]  action_reg;
    logic [31:0] key_reg, val_reg, hash_reg;
    logic [32:0] rem_reg;
    logic [5:0]  bit_reg;
    logic [htik_pkg::CFG_W-1:0] div_reg;
    logic [SW-1:0] base_reg;
    logic [UW:0]   sub_reg, chk_reg;
    logic          hit_reg, free_reg;
    logic [SW-1:0] hit_idx_reg, free_idx_reg;
    logic [31:0]   hit_val_reg, rd_key_reg, rd_val_reg;
    logic          rd_vld_reg, rd_in_reg;
    logic [htik_pkg::CNT_W-1:0] count_reg;
    logic [SW:0]   clr_reg;

    logic [31:0] key_mem [htik_pkg::TOTAL_SLOTS];
    logic [31:0] val_mem [htik_pkg::TOTAL_SLOTS];
    logic        valid_mem [htik_pkg::TOTAL_SLOTS];

    logic [31:0] xs;
    logic [32:0] trial;
    logic [SW:0] rd_idx_w, chk_idx_w;
    logic [htik_pkg::CFG_W-1:0] eff;

    assign xs = (hash_reg >> htik_pkg::MIX_SHIFT) ^ hash_reg;
    assign trial = {rem_reg[31:0], hash_reg[31]};
    assign rd_idx_w  = {1'b0, base_reg} + (SW+1)'(sub_reg);
    assign chk_idx_w = {1'b0, base_reg} + (SW+1)'(chk_reg);

    // clamp the configured divisor
    always_comb begin
        if (bucket_count == '0)
            eff = htik_pkg::CFG_W'(1);
        else if (bucket_count > htik_pkg::CFG_W'(htik_pkg::NUM_BUCKETS))
            eff = htik_pkg::CFG_W'(htik_pkg::NUM_BUCKETS);
        else
            eff = bucket_count;
    end

    assign sts.mod_done  = (bit_reg == 6'd0);
    assign sts.scan_last = (chk_reg == (UW+1)'(htik_pkg::SLOTS_PER_BUCKET - 1)) ||
                           (chk_idx_w >= (SW+1)'(htik_pkg::TOTAL_SLOTS - 1));
    assign sts.act_valid = (action_reg <= htik_pkg::ACT_REMOVE);
    assign sts.clr_done  = clr_reg[SW];

    // hash, divide and scan
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg <= in_action;
            key_reg    <= in_key;
            val_reg    <= in_value;
            hash_reg   <= in_key;
        end
        if (cmd.mix_a || cmd.mix_b)
            hash_reg <= xs * htik_pkg::MIX_MUL;
        if (cmd.mix_c) begin
            hash_reg <= xs;
            rem_reg  <= '0;
            bit_reg  <= 6'd32;
            div_reg  <= eff;
        end
        if (cmd.mod_step) begin
            // restoring step: quotient bits are not kept
            if (trial >= {24'd0, div_reg})
                rem_reg <= trial - {24'd0, div_reg};
            else
                rem_reg <= trial;
            hash_reg <= {hash_reg[30:0], 1'b0};
            bit_reg  <= bit_reg - 6'd1;
            sub_reg  <= '0;
            chk_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            rd_in_reg <= 1'b0;
        end
        if (cmd.scan_rd) begin
            if (sub_reg == '0)
                base_reg <= SW'(rem_reg[htik_pkg::BKT_W-1:0] * htik_pkg::SLOTS_PER_BUCKET);
            rd_in_reg <= 1'b1;
        end
        if (cmd.scan_chk) begin
            if (rd_vld_reg) begin
                if (!hit_reg && rd_key_reg == key_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= chk_idx_w[SW-1:0];
                    hit_val_reg <= rd_val_reg;
                end
            end else if (!free_reg) begin
                free_reg     <= 1'b1;
                free_idx_reg <= chk_idx_w[SW-1:0];
            end
            chk_reg <= chk_reg + 1'b1;
            sub_reg <= chk_reg + (UW+1)'(2);
        end else if (cmd.scan_rd && sub_reg == '0) begin
            sub_reg <= (UW+1)'(1);
        end
    end

    // registered slot read; base comes from rem on the first read
    logic [SW-1:0] rd_addr;
    assign rd_addr = (sub_reg == '0 && cmd.scan_rd)
        ? SW'(rem_reg[htik_pkg::BKT_W-1:0] * htik_pkg::SLOTS_PER_BUCKET)
        : rd_idx_w[SW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd || cmd.scan_chk) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_val_reg <= val_mem[rd_addr];
            rd_vld_reg <= valid_mem[rd_addr];
        end
        if (cmd.commit && action_reg == htik_pkg::ACT_PUT) begin
            if (hit_reg)
                val_mem[hit_idx_reg] <= val_reg;
            else if (free_reg) begin
                key_mem[free_idx_reg] <= key_reg;
                val_mem[free_idx_reg] <= val_reg;
            end
        end
        // clear valid bits after reset, then track inserts and removes
        if (!clr_reg[SW])
            valid_mem[clr_reg[SW-1:0]] <= 1'b0;
        else if (cmd.commit && action_reg == htik_pkg::ACT_PUT && !hit_reg && free_reg)
            valid_mem[free_idx_reg] <= 1'b1;
        else if (cmd.commit && action_reg == htik_pkg::ACT_REMOVE && hit_reg)
            valid_mem[hit_idx_reg] <= 1'b0;
    end

    // reset clear pointer and count; advance the clear, update count and result on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (!clr_reg[SW])
                clr_reg <= clr_reg + 1'b1;
            if (cmd.commit) begin
                res_found  <= 1'b0;
                res_value  <= '0;
                res_status <= htik_pkg::ST_OK;
                case (action_reg)
                    htik_pkg::ACT_PUT: begin
                        if (hit_reg)
                            res_found <= 1'b1;
                        else if (free_reg)
                            count_reg <= count_reg + 1'b1;
                        else
                            res_status <= htik_pkg::ST_FULL;
                    end
                    htik_pkg::ACT_GET: begin
                        if (hit_reg) begin
                            res_found <= 1'b1;
                            res_value <= hit_val_reg;
                        end else
                            res_status <= htik_pkg::ST_NOT_FND;
                    end
                    htik_pkg::ACT_REMOVE: begin
                        if (hit_reg) begin
                            res_found <= 1'b1;
                            if (count_reg != '0)
                                count_reg <= count_reg - 1'b1;
                        end else
                            res_status <= htik_pkg::ST_NOT_FND;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign res_count = count_reg;

    // a slot check always follows its read
    a_rd_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_chk |-> rd_in_reg)
        else $error("slot check without read");
    a_mod_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mod_step |-> bit_reg != 6'd0)
        else $error("modulo stepped past end");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= htik_pkg::CNT_W'(htik_pkg::TOTAL_SLOTS))
        else $error("entry count overflow");

endmodule

// File: hdl/htik_ctrl.sv
// ----------------------------------------------------------------------------
// htik_ctrl: request sequencer
// Steps one item through hash, modulo, slot scan and commit, and holds the
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module htik_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output htik_pkg::htik_cmd_t cmd,
    input  htik_pkg::htik_sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MIXA = 8'b0000_0010,
        S_MIXB = 8'b0000_0100,
        S_MIXC = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_RD   = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_CMT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    // take an item in idle once the store is cleared and the result register frees
    assign in_ready  = (state_reg == S_IDLE) && sts.clr_done && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        case (state_reg)
            S_IDLE: if (in_valid && in_ready) begin
                cmd.load   = 1'b1;
                state_next = S_MIXA;
            end
            S_MIXA: begin cmd.mix_a = 1'b1; state_next = S_MIXB; end
            S_MIXB: begin cmd.mix_b = 1'b1; state_next = S_MIXC; end
            S_MIXC: begin
                cmd.mix_c  = 1'b1;
                state_next = sts.act_valid ? S_MOD : S_CMT;
            end
            S_MOD: begin
                if (sts.mod_done) state_next = S_RD;
                else cmd.mod_step = 1'b1;
            end
            S_RD: begin cmd.scan_rd = 1'b1; state_next = S_CHK; end
            S_CHK: begin
                cmd.scan_chk = 1'b1;
                if (sts.scan_last) state_next = S_CMT;
            end
            S_CMT: begin
                cmd.commit  = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while busy");
    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!ovalid_reg || out_ready))
        else $error("result overwritten");
    a_cmt_then_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> ovalid_reg)
        else $error("result lost");

endmodule
